### hdl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// shared constants for the indexed min-heap queue: field widths, command
// and error codes, parameter defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;

    // field widths
    localparam int CMD_W       = 3;
    localparam int ID_W        = 10;
    localparam int KEY_IN_W    = 16;
    localparam int COUNT_OUT_W = 11;
    localparam int ERR_W       = 2;

    // id space covered by the position table
    localparam int ID_SPACE = 1024;

    // parameter defaults
    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd3;

endpackage
`default_nettype wire

### hdl/indexed_min_heap_queue_core.sv
// steps, accept to result valid: clear, unused commands, full insert and empty remove go straight
//   to the response; contains, duplicate insert and absent update first look up position and slot;
//   insert and decrease key then climb until the root or a parent no larger stops them; remove
//   minimum reads the root, and unless it was the last item, sinks until no smaller child is left
// throughput: one transaction at a time; input stalls from accept until the result enters
//   the output register. reset: item count cleared at once, no clearing pass, rams untouched
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core
// indexed binary min-heap of ids ordered by key, with a per-id position table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_core #(
    parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [imhq_pkg::CMD_W-1:0]         command,
    input  wire logic [imhq_pkg::ID_W-1:0]          item_id,
    input  wire logic [imhq_pkg::KEY_IN_W-1:0]      key,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [imhq_pkg::ID_W-1:0]          out_id,
    output logic      [imhq_pkg::KEY_IN_W-1:0]      out_key,
    output logic                                    found,
    output logic      [imhq_pkg::COUNT_OUT_W-1:0]   item_count,
    output logic                                    is_empty,
    output logic      [imhq_pkg::ERR_W-1:0]         error_code
);

    localparam int ID_W   = imhq_pkg::ID_W;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = CNT_W + 1;
    localparam int ENT_W  = ID_W + KEY_BITS;

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LK_POS  = 4'd1;
    localparam logic [3:0] ST_LK_SLOT = 4'd2;
    localparam logic [3:0] ST_UP_CHK  = 4'd3;
    localparam logic [3:0] ST_UP_CMP  = 4'd4;
    localparam logic [3:0] ST_RM_ROOT = 4'd5;
    localparam logic [3:0] ST_RM_LAST = 4'd6;
    localparam logic [3:0] ST_DN_CHK  = 4'd7;
    localparam logic [3:0] ST_DN_LEFT = 4'd8;
    localparam logic [3:0] ST_DN_CMP  = 4'd9;
    localparam logic [3:0] ST_FIN     = 4'd10;
    localparam logic [3:0] ST_RESP    = 4'd11;

    logic [3:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [imhq_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [ID_W-1:0]                 id_reg, id_next;
    logic [KEY_BITS-1:0]             key_reg, key_next;
    logic [SLOT_W-1:0]               lpos_reg, lpos_next;
    logic                            plt_reg, plt_next;
    logic [SLOT_W-1:0]               cur_reg, cur_next;
    logic [ID_W-1:0]                 cur_id_reg, cur_id_next;
    logic [KEY_BITS-1:0]             cur_key_reg, cur_key_next;
    logic [ENT_W-1:0]                left_reg, left_next;
    logic [ID_W-1:0]                 res_id_reg, res_id_next;
    logic [KEY_BITS-1:0]             res_key_reg, res_key_next;
    logic                            res_found_reg, res_found_next;
    logic [imhq_pkg::ERR_W-1:0]      res_err_reg, res_err_next;

    logic                            out_valid_reg, out_valid_next;
    logic [ID_W-1:0]                 out_id_reg, out_id_next;
    logic [imhq_pkg::KEY_IN_W-1:0]   out_key_reg, out_key_next;
    logic                            out_found_reg, out_found_next;
    logic [imhq_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic                            out_empty_reg, out_empty_next;
    logic [imhq_pkg::ERR_W-1:0]      out_err_reg, out_err_next;

    // ram ports
    logic                            h_wr_en, h_rd_en;
    logic [SLOT_W-1:0]               h_wr_addr, h_rd_addr;
    logic [ENT_W-1:0]                h_wr_data, h_rd_data;
    logic                            p_wr_en, p_rd_en;
    logic [ID_W-1:0]                 p_wr_addr, p_rd_addr;
    logic [SLOT_W-1:0]               p_wr_data, p_rd_data;

    // derived values
    logic                            in_fire, out_free, hold;
    logic [SLOT_W-1:0]               parent;
    logic [IDX_W-1:0]                left_idx, right_idx, count_ext;
    logic                            left_ok, right_ok, pick_right;
    logic [ID_W-1:0]                 rd_id, left_id;
    logic [KEY_BITS-1:0]             rd_key, left_key;
    logic [CNT_W-1:0]                count_dec;

    imhq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_heap_ram (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    imhq_ram #(.WIDTH(SLOT_W), .DEPTH(imhq_pkg::ID_SPACE)) u_pos_ram (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_en   (p_rd_en),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    // handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // heap index arithmetic
    assign rd_id     = h_rd_data[ENT_W-1:KEY_BITS];
    assign rd_key    = h_rd_data[KEY_BITS-1:0];
    assign left_id   = left_reg[ENT_W-1:KEY_BITS];
    assign left_key  = left_reg[KEY_BITS-1:0];
    assign parent    = (cur_reg - SLOT_W'(1)) >> 1;
    assign left_idx  = (IDX_W'(cur_reg) << 1) + IDX_W'(1);
    assign right_idx = left_idx + IDX_W'(1);
    assign count_ext = IDX_W'(count_reg);
    assign left_ok   = left_idx < count_ext;
    assign right_ok  = right_idx < count_ext;
    assign pick_right = right_ok && (rd_key < left_key);
    assign hold      = plt_reg && (rd_id == id_reg);
    assign count_dec = count_reg - CNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        lpos_next      = lpos_reg;
        plt_next       = plt_reg;
        cur_next       = cur_reg;
        cur_id_next    = cur_id_reg;
        cur_key_next   = cur_key_reg;
        left_next      = left_reg;
        res_id_next    = res_id_reg;
        res_key_next   = res_key_reg;
        res_found_next = res_found_reg;
        res_err_next   = res_err_reg;
        h_wr_en   = 1'b0;
        h_wr_addr = cur_reg;
        h_wr_data = h_rd_data;
        h_rd_en   = 1'b0;
        h_rd_addr = '0;
        p_wr_en   = 1'b0;
        p_wr_addr = rd_id;
        p_wr_data = cur_reg;
        p_rd_en   = 1'b0;
        p_rd_addr = item_id;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next       = command;
                    id_next        = item_id;
                    key_next       = KEY_BITS'(key);
                    res_id_next    = '0;
                    res_key_next   = '0;
                    res_found_next = 1'b0;
                    res_err_next   = imhq_pkg::ERR_OK;
                    p_rd_en        = 1'b1;
                    h_rd_en        = 1'b1;
                    state_next     = ST_RESP;
                    case (command) inside
                        imhq_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_err_next = imhq_pkg::ERR_FULL;
                            end
                            else
                            begin
                                state_next = ST_LK_POS;
                            end
                        end
                        imhq_pkg::CMD_DECREASE, imhq_pkg::CMD_CONTAINS:
                        begin
                            state_next = ST_LK_POS;
                        end
                        imhq_pkg::CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_err_next = imhq_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_RM_ROOT;
                            end
                        end
                        imhq_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_LK_POS:
            begin
                // look up the slot the id claims
                lpos_next  = p_rd_data;
                plt_next   = CNT_W'(p_rd_data) < count_reg;
                h_rd_en    = 1'b1;
                h_rd_addr  = p_rd_data;
                state_next = ST_LK_SLOT;
            end
            ST_LK_SLOT:
            begin
                state_next = ST_RESP;
                case (cmd_reg)
                    imhq_pkg::CMD_INSERT:
                    begin
                        if (!hold)
                        begin
                            cur_next     = count_reg[SLOT_W-1:0];
                            cur_id_next  = id_reg;
                            cur_key_next = key_reg;
                            count_next   = count_reg + CNT_W'(1);
                            state_next   = ST_UP_CHK;
                        end
                    end
                    imhq_pkg::CMD_DECREASE:
                    begin
                        if (!hold)
                        begin
                            res_err_next = imhq_pkg::ERR_ABSENT;
                        end
                        else
                        begin
                            cur_next     = lpos_reg;
                            cur_id_next  = id_reg;
                            cur_key_next = key_reg;
                            state_next   = ST_UP_CHK;
                        end
                    end
                    default:
                    begin
                        res_found_next = hold;
                    end
                endcase
            end
            ST_UP_CHK:
            begin
                if (cur_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = parent;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                // move a larger parent down into the hole
                if (rd_key > cur_key_reg)
                begin
                    h_wr_en    = 1'b1;
                    p_wr_en    = 1'b1;
                    cur_next   = parent;
                    state_next = ST_UP_CHK;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RM_ROOT:
            begin
                res_id_next  = rd_id;
                res_key_next = rd_key;
                count_next   = count_dec;
                if (count_dec == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = count_dec[SLOT_W-1:0];
                    state_next = ST_RM_LAST;
                end
            end
            ST_RM_LAST:
            begin
                cur_next     = '0;
                cur_id_next  = rd_id;
                cur_key_next = rd_key;
                state_next   = ST_DN_CHK;
            end
            ST_DN_CHK:
            begin
                if (!left_ok)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = left_idx[SLOT_W-1:0];
                    state_next = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT:
            begin
                left_next  = h_rd_data;
                h_rd_en    = right_ok;
                h_rd_addr  = right_idx[SLOT_W-1:0];
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                // smaller child, left wins a tie, moves up into the hole
                state_next = ST_FIN;
                if (pick_right)
                begin
                    if (rd_key < cur_key_reg)
                    begin
                        h_wr_en    = 1'b1;
                        p_wr_en    = 1'b1;
                        cur_next   = right_idx[SLOT_W-1:0];
                        state_next = ST_DN_CHK;
                    end
                end
                else if (left_key < cur_key_reg)
                begin
                    h_wr_en    = 1'b1;
                    h_wr_data  = left_reg;
                    p_wr_en    = 1'b1;
                    p_wr_addr  = left_id;
                    cur_next   = left_idx[SLOT_W-1:0];
                    state_next = ST_DN_CHK;
                end
            end
            ST_FIN:
            begin
                // settle the moving entry in its final slot
                h_wr_en    = 1'b1;
                h_wr_data  = {cur_id_reg, cur_key_reg};
                p_wr_en    = 1'b1;
                p_wr_addr  = cur_id_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_id_next    = out_id_reg;
        out_key_next   = out_key_reg;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        out_err_next   = out_err_reg;
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_valid_next = 1'b1;
            out_id_next    = res_id_reg;
            out_key_next   = imhq_pkg::KEY_IN_W'(res_key_reg);
            out_found_next = res_found_reg;
            out_count_next = imhq_pkg::COUNT_OUT_W'(count_reg);
            out_empty_next = (count_reg == '0);
            out_err_next   = res_err_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        key_reg       <= key_next;
        lpos_reg      <= lpos_next;
        plt_reg       <= plt_next;
        cur_reg       <= cur_next;
        cur_id_reg    <= cur_id_next;
        cur_key_reg   <= cur_key_next;
        left_reg      <= left_next;
        res_id_reg    <= res_id_next;
        res_key_reg   <= res_key_next;
        res_found_reg <= res_found_next;
        res_err_reg   <= res_err_next;
        out_id_reg    <= out_id_next;
        out_key_reg   <= out_key_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_id     = out_id_reg;
    assign out_key    = out_key_reg;
    assign found      = out_found_reg;
    assign item_count = out_count_reg;
    assign is_empty   = out_empty_reg;
    assign error_code = out_err_reg;

`ifndef SYNTHESIS
    // an accepted transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start");

    // the count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("item count above capacity");

    // a finished transaction lands in the output register and frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) && out_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not delivered to output register");

    // ram writes happen only while a transaction is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (h_wr_en || p_wr_en) |-> (state_reg != ST_IDLE) && (state_reg != ST_RESP))
        else $error("ram write outside a transaction");
`endif

endmodule
`default_nettype wire

### hdl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### sim/indexed_min_heap_queue_core_test.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core_test
// drives insert, decrease key, remove minimum, contains, clear and unused command codes into
// the heap queue, takes each expected result from a typed table row or a behavioral heap and
// compares each returned transaction field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_core_test;

    localparam int CAP = imhq_pkg::CAPACITY_DEF;
    localparam int KEY_MAX = (1 << imhq_pkg::KEY_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS = 220;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [imhq_pkg::ID_W-1:0]        rid;
        logic [imhq_pkg::KEY_IN_W-1:0]    rkey;
        logic                             rfound;
        logic [imhq_pkg::COUNT_OUT_W-1:0] rcount;
        logic                             rempty;
        logic [imhq_pkg::ERR_W-1:0]       rerr;
    } heap_result_t;

    typedef struct {
        logic [imhq_pkg::CMD_W-1:0]    cmd;
        logic [imhq_pkg::ID_W-1:0]     id;
        logic [imhq_pkg::KEY_IN_W-1:0] k;
        bit                            typed;
        heap_result_t                  res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [imhq_pkg::CMD_W-1:0] command = '0;
    logic [imhq_pkg::ID_W-1:0] item_id = '0;
    logic [imhq_pkg::KEY_IN_W-1:0] key = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [imhq_pkg::ID_W-1:0] out_id;
    logic [imhq_pkg::KEY_IN_W-1:0] out_key;
    logic found;
    logic [imhq_pkg::COUNT_OUT_W-1:0] item_count;
    logic is_empty;
    logic [imhq_pkg::ERR_W-1:0] error_code;

    indexed_min_heap_queue_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .item_id(item_id), .key(key),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_id(out_id), .out_key(out_key), .found(found),
        .item_count(item_count), .is_empty(is_empty), .error_code(error_code)
    );

    always #10 clk = ~clk;

    // behavioral heap
    logic [imhq_pkg::ID_W-1:0]     heap_ids [CAP];
    logic [imhq_pkg::KEY_IN_W-1:0] heap_keys [CAP];
    int                            slot_of [imhq_pkg::ID_SPACE];
    int                            heap_fill = 0;
    heap_result_t                  pending_results [$];
    bit                            pending_typed [$];
    int                            failures = 0;
    int                            received = 0;
    bit                            stim_done = 0;
    bit                            long_holdoff = 0;
    longint                        cycles = 0;

    function automatic bit heap_holds(input int id);
        int p;
        p = slot_of[id];
        return p >= 0 && p < heap_fill && heap_ids[p] == id;
    endfunction

    function automatic void heap_swap(input int a, input int b);
        logic [imhq_pkg::ID_W-1:0] ti;
        logic [imhq_pkg::KEY_IN_W-1:0] tk;
        ti = heap_ids[a]; tk = heap_keys[a];
        heap_ids[a] = heap_ids[b]; heap_keys[a] = heap_keys[b];
        heap_ids[b] = ti; heap_keys[b] = tk;
        slot_of[heap_ids[a]] = a;
        slot_of[heap_ids[b]] = b;
    endfunction

    function automatic void heap_climb(input int p);
        int up;
        while (p > 0) begin
            up = (p - 1) / 2;
            if (heap_keys[up] > heap_keys[p]) begin
                heap_swap(up, p);
                p = up;
            end
            else break;
        end
    endfunction

    function automatic void heap_sink(input int p);
        int l, pick;
        forever begin
            l = 2 * p + 1;
            if (l >= heap_fill) break;
            pick = l;
            if (l + 1 < heap_fill && heap_keys[l + 1] < heap_keys[l]) pick = l + 1;
            if (heap_keys[pick] < heap_keys[p]) begin
                heap_swap(pick, p);
                p = pick;
            end
            else break;
        end
    endfunction

    // predicted result of one command, updates the behavioral heap
    function automatic heap_result_t heap_apply(input logic [imhq_pkg::CMD_W-1:0] cmd,
                                                input int id, input int k);
        heap_result_t r;
        int p;
        r = '0;
        case (cmd)
            imhq_pkg::CMD_INSERT: begin
                if (heap_fill >= CAP) r.rerr = imhq_pkg::ERR_FULL;
                else if (!heap_holds(id)) begin
                    p = heap_fill;
                    heap_ids[p] = imhq_pkg::ID_W'(id);
                    heap_keys[p] = imhq_pkg::KEY_IN_W'(k);
                    slot_of[id] = p;
                    heap_fill++;
                    heap_climb(p);
                end
            end
            imhq_pkg::CMD_DECREASE: begin
                if (!heap_holds(id)) r.rerr = imhq_pkg::ERR_ABSENT;
                else begin
                    p = slot_of[id];
                    heap_keys[p] = imhq_pkg::KEY_IN_W'(k);
                    heap_climb(p);
                end
            end
            imhq_pkg::CMD_REMOVE: begin
                if (heap_fill == 0) r.rerr = imhq_pkg::ERR_EMPTY;
                else begin
                    r.rid = heap_ids[0];
                    r.rkey = heap_keys[0];
                    heap_fill--;
                    heap_ids[0] = heap_ids[heap_fill];
                    heap_keys[0] = heap_keys[heap_fill];
                    slot_of[heap_ids[0]] = 0;
                    heap_sink(0);
                end
            end
            imhq_pkg::CMD_CONTAINS: r.rfound = heap_holds(id);
            imhq_pkg::CMD_CLEAR: heap_fill = 0;
            default: ;
        endcase
        r.rcount = imhq_pkg::COUNT_OUT_W'(heap_fill);
        r.rempty = (heap_fill == 0);
        return r;
    endfunction

    // one transaction on the input side; valid stays up across a zero gap
    task automatic send_command(input logic [imhq_pkg::CMD_W-1:0] cmd, input int id,
                                input int k);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        item_id <= imhq_pkg::ID_W'(id);
        key <= imhq_pkg::KEY_IN_W'(k);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_predicted(input logic [imhq_pkg::CMD_W-1:0] cmd, input int id,
                                  input int k);
        pending_results.push_back(heap_apply(cmd, id, k));
        pending_typed.push_back(1'b0);
        send_command(cmd, id, k);
    endtask

    // directed table: typed expectations where obvious, predictor otherwise
    stim_row_t directed_rows [] = '{
        '{imhq_pkg::CMD_REMOVE,   10'd0,    16'd0,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd0, 1'b1, imhq_pkg::ERR_EMPTY}},
        '{imhq_pkg::CMD_DECREASE, 10'd1023, 16'd5,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd0, 1'b1, imhq_pkg::ERR_ABSENT}},
        '{imhq_pkg::CMD_CONTAINS, 10'd0,    16'd0,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd0, 1'b1, imhq_pkg::ERR_OK}},
        '{imhq_pkg::CMD_INSERT,   10'd1023, 16'hFFFF, 1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd1, 1'b0, imhq_pkg::ERR_OK}},
        '{imhq_pkg::CMD_INSERT,   10'd0,    16'h0000, 1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd2, 1'b0, imhq_pkg::ERR_OK}},
        '{imhq_pkg::CMD_INSERT,   10'd0,    16'h1234, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_INSERT,   10'd512,  16'h8000, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_INSERT,   10'd341,  16'h8000, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_INSERT,   10'd682,  16'h8000, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_CONTAINS, 10'd1023, 16'd0,    1'b0, '{default: '0}},
        '{imhq_pkg::CMD_DECREASE, 10'd682,  16'h0000, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_DECREASE, 10'd0,    16'hFFFF, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_REMOVE,   10'd0,    16'd0,    1'b0, '{default: '0}},
        '{imhq_pkg::CMD_REMOVE,   10'd0,    16'd0,    1'b0, '{default: '0}},
        '{imhq_pkg::CMD_REMOVE,   10'd0,    16'd0,    1'b0, '{default: '0}},
        '{3'd5,                   10'd7,    16'd7,    1'b0, '{default: '0}},
        '{3'd6,                   10'd0,    16'd0,    1'b0, '{default: '0}},
        '{3'd7,                   10'd1023, 16'hFFFF, 1'b0, '{default: '0}},
        '{imhq_pkg::CMD_CLEAR,    10'd0,    16'd0,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd0, 1'b1, imhq_pkg::ERR_OK}},
        '{imhq_pkg::CMD_CONTAINS, 10'd512,  16'd0,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd0, 1'b1, imhq_pkg::ERR_OK}},
        '{imhq_pkg::CMD_DECREASE, 10'd512,  16'd0,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd0, 1'b1, imhq_pkg::ERR_ABSENT}},
        '{imhq_pkg::CMD_INSERT,   10'd512,  16'd9,    1'b1,
          '{10'd0, 16'd0, 1'b0, 11'd1, 1'b0, imhq_pkg::ERR_OK}},
        '{imhq_pkg::CMD_CONTAINS, 10'd341,  16'd0,    1'b0, '{default: '0}},
        '{imhq_pkg::CMD_CLEAR,    10'd0,    16'd0,    1'b0, '{default: '0}}
    };

    // id pools keep most ids live so lookups and updates hit
    function automatic int pick_id();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, imhq_pkg::ID_SPACE - 1);
        return $urandom_range(0, 63);
    endfunction

    function automatic int pick_key();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return KEY_MAX;
            2: return $urandom_range(0, 15);
            default: return $urandom_range(0, KEY_MAX);
        endcase
    endfunction

    // stimulus
    initial begin
        heap_result_t predicted;
        int c, fill_goal;
        for (int i = 0; i < imhq_pkg::ID_SPACE; i++) slot_of[i] = -1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            predicted = heap_apply(directed_rows[i].cmd, directed_rows[i].id,
                                   directed_rows[i].k);
            pending_results.push_back(directed_rows[i].typed ? directed_rows[i].res
                                                             : predicted);
            pending_typed.push_back(directed_rows[i].typed);
            send_command(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].k);
        end

        // receiver holds off while the sender keeps offering
        long_holdoff = 1;
        for (int i = 0; i < 12; i++) send_predicted(imhq_pkg::CMD_INSERT, 100 + i, pick_key());
        long_holdoff = 0;

        // fill to capacity once, then overflow and drain a little
        for (int i = 0; i < CAP; i++)
            send_predicted(imhq_pkg::CMD_INSERT, i, $urandom_range(0, KEY_MAX));
        send_predicted(imhq_pkg::CMD_INSERT, 5, 3);
        send_predicted(imhq_pkg::CMD_INSERT, 2000 % imhq_pkg::ID_SPACE, 0);
        for (int i = 0; i < 20; i++) send_predicted(imhq_pkg::CMD_REMOVE, 0, 0);
        send_predicted(imhq_pkg::CMD_CLEAR, 0, 0);

        // random part: phases build up and drain the heap
        fill_goal = 8;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) fill_goal = $urandom_range(1, 40);
            c = $urandom_range(0, 99);
            if (c < 2) send_predicted(imhq_pkg::CMD_CLEAR, pick_id(), pick_key());
            else if (c < 4)
                send_predicted(imhq_pkg::CMD_W'($urandom_range(5, 7)), pick_id(), pick_key());
            else if (c < 34)
                send_predicted(heap_fill < fill_goal ? imhq_pkg::CMD_INSERT
                                                     : imhq_pkg::CMD_REMOVE,
                               pick_id(), pick_key());
            else if (c < 52) send_predicted(imhq_pkg::CMD_INSERT, pick_id(), pick_key());
            else if (c < 70) send_predicted(imhq_pkg::CMD_REMOVE, pick_id(), pick_key());
            else if (c < 85) send_predicted(imhq_pkg::CMD_DECREASE, pick_id(), pick_key());
            else send_predicted(imhq_pkg::CMD_CONTAINS, pick_id(), pick_key());
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver stall pattern
    initial begin
        int hold;
        @(posedge rst_n);
        forever begin
            if (long_holdoff) begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
                wait (!long_holdoff);
                @(posedge clk);
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // result checking
    always @(posedge clk) begin
        heap_result_t want, got;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_id, out_key, found, item_count, is_empty, error_code};
            received++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result id=%0d key=%0d", $time, out_id, out_key);
                failures++;
            end
            else begin
                want = pending_results.pop_front();
                void'(pending_typed.pop_front());
                if (got.rid !== want.rid)
                    $display("%0t: out_id expected %0d actual %0d", $time, want.rid, got.rid);
                if (got.rkey !== want.rkey)
                    $display("%0t: out_key expected %0d actual %0d", $time, want.rkey, got.rkey);
                if (got.rfound !== want.rfound)
                    $display("%0t: found expected %0d actual %0d", $time, want.rfound, got.rfound);
                if (got.rcount !== want.rcount)
                    $display("%0t: item_count expected %0d actual %0d", $time, want.rcount,
                             got.rcount);
                if (got.rempty !== want.rempty)
                    $display("%0t: is_empty expected %0d actual %0d", $time, want.rempty,
                             got.rempty);
                if (got.rerr !== want.rerr)
                    $display("%0t: error_code expected %0d actual %0d", $time, want.rerr,
                             got.rerr);
                if (got !== want) failures++;
            end
        end
    end

    // end of run and timeout
    initial begin
        wait (stim_done && pending_results.size() == 0);
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("PASS indexed_min_heap_queue_core");
        else
            $display("FAIL indexed_min_heap_queue_core");
        $finish;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL indexed_min_heap_queue_core");
            $finish;
        end
    end

endmodule
`default_nettype wire
